// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL, clocked on clk_i, disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge of clk_i.
`define VAL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition at one edge implies another at the next edge.
`define VAL_ASSERT_NX(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/val_pkg.sv =====
`timescale 1ns / 1ps

package val_pkg;

  // Slot table depth and its index width.
  localparam int NumSounds = 256;
  localparam int SlotAw    = (NumSounds > 1) ? $clog2(NumSounds) : 1;

  // Global voice limit after reset.
  localparam logic [15:0] GlobalLimitRst = 16'd32;

  // Item kinds.
  localparam logic [2:0] KindRegister = 3'd0;
  localparam logic [2:0] KindPlay     = 3'd1;
  localparam logic [2:0] KindStopOne  = 3'd2;
  localparam logic [2:0] KindStopAll  = 3'd3;
  localparam logic [2:0] KindTick     = 3'd4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  sound_id;
    logic [15:0] min_interval;
    logic [7:0]  max_concurrent;
    logic [15:0] time_step;
  } item_t;

  typedef struct packed {
    logic [15:0] min_interval;
    logic [7:0]  voice_limit;
    logic [7:0]  playing;
    logic [32:0] last_play;
  } slot_t;

  typedef struct packed {
    logic [31:0] elapsed;
    logic [15:0] running_total;
    logic [8:0]  valid_count;
  } glob_t;

  typedef struct packed {
    logic        granted;
    logic        is_registered;
    logic [7:0]  playing_count;
    logic [32:0] time_since_play;
    logic [15:0] total_playing;
    logic [8:0]  registered_count;
  } result_t;

  // True when a sound id addresses an existing slot.
  function automatic logic id_in_range(input logic [7:0] id);
    return 32'(id) < NumSounds;
  endfunction

endpackage

// ===== src/val_slot_ram.sv =====
`timescale 1ns / 1ps

module val_slot_ram #(
  parameter int Width = 65,
  parameter int Depth = 256,
  localparam int Aw   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // Write one entry.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Register the read data; a same-edge write is not seen.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/val_exec.sv =====
`timescale 1ns / 1ps

module val_exec (
  input  val_pkg::item_t   item_i,
  input  logic             live_i,
  input  val_pkg::slot_t   slot_i,
  input  val_pkg::glob_t   glob_i,
  input  logic [15:0]      global_limit_i,
  output val_pkg::slot_t   slot_o,
  output logic             slot_we_o,
  output logic             set_valid_o,
  output val_pkg::glob_t   glob_o,
  output val_pkg::result_t res_o
);

  logic        in_range;
  logic        live_after;
  logic        granted;
  logic [32:0] since_cur;
  logic [32:0] since_after;
  logic [32:0] tick_sum;

  // Apply one item to the addressed slot and the global counters.
  always_comb begin
    slot_o      = slot_i;
    glob_o      = glob_i;
    slot_we_o   = 1'b0;
    set_valid_o = 1'b0;
    granted     = 1'b0;
    live_after  = live_i;
    in_range    = val_pkg::id_in_range(item_i.sound_id);
    since_cur   = {1'b0, glob_i.elapsed} - slot_i.last_play;
    tick_sum    = {1'b0, glob_i.elapsed} + {17'b0, item_i.time_step};

    case (item_i.kind)
      val_pkg::KindRegister: begin
        if (in_range) begin
          if (live_i) begin
            glob_o.running_total = glob_i.running_total - {8'b0, slot_i.playing};
          end else begin
            glob_o.valid_count = glob_i.valid_count + 9'd1;
          end
          slot_o.min_interval = item_i.min_interval;
          slot_o.voice_limit  = item_i.max_concurrent;
          slot_o.playing      = 8'd0;
          slot_o.last_play    = 33'd0 - {17'b0, item_i.min_interval};
          slot_we_o           = 1'b1;
          set_valid_o         = 1'b1;
          live_after          = 1'b1;
        end
      end
      val_pkg::KindPlay: begin
        if (live_i && (slot_i.playing < slot_i.voice_limit)
            && (glob_i.running_total < global_limit_i)
            && (since_cur >= {17'b0, slot_i.min_interval})) begin
          slot_o.playing       = slot_i.playing + 8'd1;
          slot_o.last_play     = {1'b0, glob_i.elapsed};
          glob_o.running_total = glob_i.running_total + 16'd1;
          slot_we_o            = 1'b1;
          granted              = 1'b1;
        end
      end
      val_pkg::KindStopOne: begin
        if (live_i && (slot_i.playing != 8'd0)) begin
          slot_o.playing       = slot_i.playing - 8'd1;
          glob_o.running_total = glob_i.running_total - 16'd1;
          slot_we_o            = 1'b1;
        end
      end
      val_pkg::KindStopAll: begin
        if (live_i) begin
          slot_o.playing       = 8'd0;
          glob_o.running_total = glob_i.running_total - {8'b0, slot_i.playing};
          slot_we_o            = 1'b1;
        end
      end
      val_pkg::KindTick: begin
        // Saturate elapsed time at the top of its range.
        glob_o.elapsed = tick_sum[32] ? 32'hFFFF_FFFF : tick_sum[31:0];
      end
      default: begin
      end
    endcase

    since_after = {1'b0, glob_o.elapsed} - slot_o.last_play;

    // Report the slot and table after the item.
    res_o.granted          = granted;
    res_o.is_registered    = live_after;
    res_o.playing_count    = live_after ? slot_o.playing : 8'd0;
    res_o.time_since_play  = live_after ? since_after : 33'd0;
    res_o.total_playing    = glob_o.running_total;
    res_o.registered_count = glob_o.valid_count;
  end

endmodule

// ===== src/voice_admission_limiter.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake                 Payload
// item      in         start_i, busy_o           kind_i, sound_id_i, min_interval_i,
//                                                max_concurrent_i, time_step_i
// result    out        done_o (one-cycle strobe) granted_o, is_registered_o,
//                                                playing_count_o, time_since_play_o,
//                                                total_playing_o, registered_count_o
// config    in         cfg_valid_i, cfg_ready_o  cfg_data_i (global_limit)
//
// One item is taken every cycle; busy_o stays low and cfg_ready_o stays high.
// The accepting edge also registers the slot RAM read; the next edge registers
// the result, so done_o is high in the cycle after that edge. The slot written
// by the previous item is forwarded around the RAM read.
// Reset clears all slot valid bits (flip-flops) at once, so no clearing pass.
// The receiver cannot stall: each result is shown for exactly one cycle.
`include "assert_macros.svh"

module voice_admission_limiter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  kind_i,
  input  logic [7:0]  sound_id_i,
  input  logic [15:0] min_interval_i,
  input  logic [7:0]  max_concurrent_i,
  input  logic [15:0] time_step_i,
  output logic        done_o,
  output logic        granted_o,
  output logic        is_registered_o,
  output logic [7:0]  playing_count_o,
  output logic [32:0] time_since_play_o,
  output logic [15:0] total_playing_o,
  output logic [8:0]  registered_count_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  localparam int Aw = val_pkg::SlotAw;
  localparam int SlotW = $bits(val_pkg::slot_t);

  logic                         stage_vld_q;
  val_pkg::item_t               item_q;
  logic [val_pkg::NumSounds-1:0] valid_q;
  val_pkg::glob_t               glob_q;
  logic [15:0]                  global_limit_q;
  logic                         fwd_vld_q;
  logic [Aw-1:0]                fwd_idx_q;
  val_pkg::slot_t               fwd_slot_q;
  logic                         done_q;
  val_pkg::result_t             res_q;

  logic [Aw-1:0]    stage_idx;
  logic [SlotW-1:0] ram_rdata;
  val_pkg::slot_t   slot_cur;
  logic             live;
  val_pkg::slot_t   slot_d;
  logic             slot_we;
  logic             set_valid;
  val_pkg::glob_t   glob_d;
  val_pkg::result_t res_d;
  logic             ram_we;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Hold the accepted item for the execute stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_vld_q <= 1'b0;
    end else begin
      stage_vld_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      item_q <= '{kind: kind_i, sound_id: sound_id_i, min_interval: min_interval_i,
                  max_concurrent: max_concurrent_i, time_step: time_step_i};
    end
  end

  assign stage_idx = Aw'(item_q.sound_id);
  assign ram_we    = stage_vld_q && slot_we;

  val_slot_ram #(
    .Width (SlotW),
    .Depth (val_pkg::NumSounds)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (stage_idx),
    .wdata_i (slot_d),
    .raddr_i (Aw'(sound_id_i)),
    .rdata_o (ram_rdata)
  );

  // Forward the slot written on the previous edge.
  assign slot_cur = (fwd_vld_q && (fwd_idx_q == stage_idx))
                    ? fwd_slot_q : val_pkg::slot_t'(ram_rdata);
  assign live     = val_pkg::id_in_range(item_q.sound_id) && valid_q[stage_idx];

  val_exec u_exec (
    .item_i         (item_q),
    .live_i         (live),
    .slot_i         (slot_cur),
    .glob_i         (glob_q),
    .global_limit_i (global_limit_q),
    .slot_o         (slot_d),
    .slot_we_o      (slot_we),
    .set_valid_o    (set_valid),
    .glob_o         (glob_d),
    .res_o          (res_d)
  );

  // Capture the last RAM write for forwarding.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_vld_q <= 1'b0;
    end else begin
      fwd_vld_q <= ram_we;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      fwd_idx_q  <= stage_idx;
      fwd_slot_q <= slot_d;
    end
  end

  // Update valid bits, global counters and the configured limit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q        <= '0;
      glob_q         <= '0;
      global_limit_q <= val_pkg::GlobalLimitRst;
    end else begin
      if (stage_vld_q) begin
        glob_q <= glob_d;
        if (set_valid) begin
          valid_q[stage_idx] <= 1'b1;
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        global_limit_q <= cfg_data_i;
      end
    end
  end

  // Register the result and strobe it for one cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= stage_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_vld_q) begin
      res_q <= res_d;
    end
  end

  assign done_o             = done_q;
  assign granted_o          = res_q.granted;
  assign is_registered_o    = res_q.is_registered;
  assign playing_count_o    = res_q.playing_count;
  assign time_since_play_o  = res_q.time_since_play;
  assign total_playing_o    = res_q.total_playing;
  assign registered_count_o = res_q.registered_count;

  `VAL_ASSERT(a_done_follows_item, (start_i && !busy_o) |-> ##2 done_o, "result missing")
  `VAL_ASSERT(a_done_has_item, done_o |-> $past(start_i, 2), "result without item")
  `VAL_ASSERT(a_grant_live,
              (done_o && granted_o) |-> (is_registered_o && playing_count_o != 8'd0),
              "grant on empty slot")
  `VAL_ASSERT(a_unreg_zero,
              (done_o && !is_registered_o)
                |-> (playing_count_o == 8'd0 && time_since_play_o == 33'd0),
              "unregistered slot reports state")
  `VAL_ASSERT_NX(a_idle_holds_total, !stage_vld_q, $stable(glob_q), "counters moved without item")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  // Unused item kinds: the block must leave its state alone on these.
  localparam logic [2:0] KindSpare5 = 3'd5;
  localparam logic [2:0] KindSpare6 = 3'd6;
  localparam logic [2:0] KindSpare7 = 3'd7;

  localparam int WatchdogLimit = 2000;
  localparam int MaxReported   = 10;

  typedef struct {
    val_pkg::item_t   it;
    bit               fixed;
    val_pkg::result_t res;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [2:0]  kind_i = '0;
  logic [7:0]  sound_id_i = '0;
  logic [15:0] min_interval_i = '0;
  logic [7:0]  max_concurrent_i = '0;
  logic [15:0] time_step_i = '0;
  logic        done_o;
  logic        granted_o;
  logic        is_registered_o;
  logic [7:0]  playing_count_o;
  logic [32:0] time_since_play_o;
  logic [15:0] total_playing_o;
  logic [8:0]  registered_count_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;

  // Side channel that travels with each item: a hand-typed result, if any.
  bit               row_fixed = 1'b0;
  val_pkg::result_t row_expect = '0;

  // Mirror of the slot table and the global counters.
  bit [val_pkg::NumSounds-1:0] slot_on = '0;
  bit [15:0] slot_gap    [val_pkg::NumSounds];
  bit [7:0]  slot_cap    [val_pkg::NumSounds];
  bit [7:0]  slot_voices [val_pkg::NumSounds];
  bit [32:0] slot_stamp  [val_pkg::NumSounds];
  bit [31:0] clock_ticks = '0;
  bit [15:0] voices_total = '0;
  bit [8:0]  slots_taken = '0;
  bit [15:0] voice_cap = val_pkg::GlobalLimitRst;

  val_pkg::result_t pending_results [$];
  row_t             dir_rows [$];
  int               error_count = 0;
  int               quiet_cycles = 0;
  int               idle_pct = 0;

  voice_admission_limiter DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .kind_i             (kind_i),
    .sound_id_i         (sound_id_i),
    .min_interval_i     (min_interval_i),
    .max_concurrent_i   (max_concurrent_i),
    .time_step_i        (time_step_i),
    .done_o             (done_o),
    .granted_o          (granted_o),
    .is_registered_o    (is_registered_o),
    .playing_count_o    (playing_count_o),
    .time_since_play_o  (time_since_play_o),
    .total_playing_o    (total_playing_o),
    .registered_count_o (registered_count_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_data_i         (cfg_data_i)
  );

  // Clock: 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Apply one item to the mirrored table and return the status it causes.
  function automatic val_pkg::result_t predict_admission(input val_pkg::item_t it);
    val_pkg::result_t res;
    logic             live;
    logic [7:0]       id;
    logic [32:0]      since;
    logic [32:0]      sum;
    res = '0;
    id = it.sound_id;
    live = (32'(id) < val_pkg::NumSounds) && slot_on[id];
    since = {1'b0, clock_ticks} - slot_stamp[id];
    case (it.kind)
      val_pkg::KindRegister: begin
        if (32'(id) < val_pkg::NumSounds) begin
          // Replacing a live slot drops its voices; a fresh one adds a slot.
          if (live) voices_total = voices_total - 16'(slot_voices[id]);
          else slots_taken = slots_taken + 9'd1;
          slot_on[id] = 1'b1;
          slot_gap[id] = it.min_interval;
          slot_cap[id] = it.max_concurrent;
          slot_voices[id] = '0;
          slot_stamp[id] = 33'd0 - 33'(it.min_interval);
        end
      end
      val_pkg::KindPlay: begin
        if (live && slot_voices[id] < slot_cap[id] && voices_total < voice_cap &&
            since >= 33'(slot_gap[id])) begin
          slot_voices[id] = slot_voices[id] + 8'd1;
          voices_total = voices_total + 16'd1;
          slot_stamp[id] = {1'b0, clock_ticks};
          res.granted = 1'b1;
        end
      end
      val_pkg::KindStopOne: begin
        if (live && slot_voices[id] != 8'd0) begin
          slot_voices[id] = slot_voices[id] - 8'd1;
          voices_total = voices_total - 16'd1;
        end
      end
      val_pkg::KindStopAll: begin
        if (live) begin
          voices_total = voices_total - 16'(slot_voices[id]);
          slot_voices[id] = '0;
        end
      end
      val_pkg::KindTick: begin
        // Saturate elapsed time at the top of 32 bits.
        sum = {1'b0, clock_ticks} + 33'(it.time_step);
        clock_ticks = sum[32] ? '1 : sum[31:0];
      end
      default: ;
    endcase
    live = (32'(id) < val_pkg::NumSounds) && slot_on[id];
    res.is_registered = live;
    if (live) begin
      res.playing_count = slot_voices[id];
      res.time_since_play = {1'b0, clock_ticks} - slot_stamp[id];
    end
    res.total_playing = voices_total;
    res.registered_count = slots_taken;
    return res;
  endfunction

  function automatic row_t mk_row(input logic [2:0] k, input logic [7:0] id,
                                  input logic [15:0] ivl, input logic [7:0] cap,
                                  input logic [15:0] stp, input bit fixed,
                                  input logic g, input logic r, input logic [7:0] n,
                                  input logic [32:0] tsp, input logic [15:0] tot,
                                  input logic [8:0] regs);
    row_t row;
    row.it = {k, id, ivl, cap, stp};
    row.fixed = fixed;
    row.res = {g, r, n, tsp, tot, regs};
    return row;
  endfunction

  // Random item: mostly traffic on a few hot slots, some noise elsewhere.
  function automatic val_pkg::item_t rand_item();
    val_pkg::item_t it;
    int             r;
    r = $urandom_range(99);
    if (r < 10) it.kind = val_pkg::KindRegister;
    else if (r < 50) it.kind = val_pkg::KindPlay;
    else if (r < 65) it.kind = val_pkg::KindStopOne;
    else if (r < 70) it.kind = val_pkg::KindStopAll;
    else if (r < 95) it.kind = val_pkg::KindTick;
    else it.kind = 3'($urandom_range(7, 5));
    it.sound_id = ($urandom_range(99) < 85) ? 8'($urandom_range(7)) : 8'($urandom);
    it.min_interval = ($urandom_range(99) < 80) ? 16'($urandom_range(24)) : 16'($urandom);
    it.max_concurrent = ($urandom_range(99) < 80) ? 8'($urandom_range(6)) : 8'($urandom);
    it.time_step = ($urandom_range(99) < 85) ? 16'($urandom_range(30)) : 16'($urandom);
    return it;
  endfunction

  task automatic report_mismatch(input string what, input val_pkg::result_t want,
                                 input val_pkg::result_t got);
    error_count++;
    if (error_count <= MaxReported) begin
      $write("%0t %s: want g=%0b r=%0b n=%0d t=%0d tot=%0d regs=%0d",
             $time, what, want.granted, want.is_registered, want.playing_count,
             want.time_since_play, want.total_playing, want.registered_count);
      $display(" | got g=%0b r=%0b n=%0d t=%0d tot=%0d regs=%0d",
               got.granted, got.is_registered, got.playing_count,
               got.time_since_play, got.total_playing, got.registered_count);
    end
  endtask

  // Hold one item on the ports until the block takes it; idle first at random.
  task automatic send_item(input val_pkg::item_t it, input bit fixed,
                           input val_pkg::result_t res);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i          <= 1'b1;
    kind_i           <= it.kind;
    sound_id_i       <= it.sound_id;
    min_interval_i   <= it.min_interval;
    max_concurrent_i <= it.max_concurrent;
    time_step_i      <= it.time_step;
    row_fixed        <= fixed;
    row_expect       <= res;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) send_item(rand_item(), 1'b0, '0);
  endtask

  // Drain the block, then write the global voice limit.
  task automatic set_voice_cap(input logic [15:0] value);
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Check results against the oldest expectation, then track accepted traffic.
  always @(posedge clk_i) begin : monitor
    val_pkg::result_t got;
    val_pkg::result_t want;
    val_pkg::item_t   taken;
    if (rst_ni) begin
      if (done_o) begin
        got = {granted_o, is_registered_o, playing_count_o, time_since_play_o,
               total_playing_o, registered_count_o};
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", '0, got);
        end else begin
          want = pending_results.pop_front();
          if (got.granted !== want.granted || got.is_registered !== want.is_registered ||
              got.playing_count !== want.playing_count ||
              got.time_since_play !== want.time_since_play ||
              got.total_playing !== want.total_playing ||
              got.registered_count !== want.registered_count)
            report_mismatch("mismatch", want, got);
        end
      end
      if (cfg_valid_i && cfg_ready_o) voice_cap = cfg_data_i;
      if (start_i && !busy_o) begin
        taken = {kind_i, sound_id_i, min_interval_i, max_concurrent_i, time_step_i};
        want = predict_admission(taken);
        pending_results.push_back(row_fixed ? row_expect : want);
      end
    end
  end

  // End the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    // Directed table: empty table first, then one slot walked through its limits.
    dir_rows.push_back(mk_row(val_pkg::KindPlay, 8'd0, 16'd0, 8'd0, 16'd0,
                              1, 0, 0, 8'd0, 33'd0, 16'd0, 9'd0));
    dir_rows.push_back(mk_row(val_pkg::KindStopOne, 8'd255, 16'd0, 8'd0, 16'd0,
                              1, 0, 0, 8'd0, 33'd0, 16'd0, 9'd0));
    dir_rows.push_back(mk_row(val_pkg::KindStopAll, 8'd7, 16'd0, 8'd0, 16'd0,
                              1, 0, 0, 8'd0, 33'd0, 16'd0, 9'd0));
    dir_rows.push_back(mk_row(KindSpare5, 8'd3, 16'd0, 8'd0, 16'd0,
                              1, 0, 0, 8'd0, 33'd0, 16'd0, 9'd0));
    dir_rows.push_back(mk_row(KindSpare7, 8'd255, 16'hFFFF, 8'hFF, 16'hFFFF,
                              1, 0, 0, 8'd0, 33'd0, 16'd0, 9'd0));
    dir_rows.push_back(mk_row(KindSpare6, 8'd128, 16'h5555, 8'hAA, 16'hAAAA,
                              0, 0, 0, 8'd0, 33'd0, 16'd0, 9'd0));
    dir_rows.push_back(mk_row(val_pkg::KindRegister, 8'd0, 16'd0, 8'hFF, 16'd0,
                              1, 0, 1, 8'd0, 33'd0, 16'd0, 9'd1));
    dir_rows.push_back(mk_row(val_pkg::KindRegister, 8'd255, 16'hFFFF, 8'd2, 16'd0,
                              1, 0, 1, 8'd0, 33'd65535, 16'd0, 9'd2));
    // An immediate play after register passes the interval test.
    dir_rows.push_back(mk_row(val_pkg::KindPlay, 8'd255, 16'd0, 8'd0, 16'd0,
                              1, 1, 1, 8'd1, 33'd0, 16'd1, 9'd2));
    dir_rows.push_back(mk_row(val_pkg::KindPlay, 8'd255, 16'd0, 8'd0, 16'd0,
                              1, 0, 1, 8'd1, 33'd0, 16'd1, 9'd2));
    dir_rows.push_back(mk_row(val_pkg::KindTick, 8'd255, 16'd0, 8'd0, 16'hFFFF,
                              1, 0, 1, 8'd1, 33'd65535, 16'd1, 9'd2));
    dir_rows.push_back(mk_row(val_pkg::KindPlay, 8'd255, 16'd0, 8'd0, 16'd0,
                              1, 1, 1, 8'd2, 33'd0, 16'd2, 9'd2));
    dir_rows.push_back(mk_row(val_pkg::KindTick, 8'd255, 16'd0, 8'd0, 16'hFFFF,
                              1, 0, 1, 8'd2, 33'd65535, 16'd2, 9'd2));
    // Per-sound limit reached.
    dir_rows.push_back(mk_row(val_pkg::KindPlay, 8'd255, 16'd0, 8'd0, 16'd0,
                              1, 0, 1, 8'd2, 33'd65535, 16'd2, 9'd2));
    // Zero voice limit refuses every play.
    dir_rows.push_back(mk_row(val_pkg::KindRegister, 8'd1, 16'd0, 8'd0, 16'd0,
                              1, 0, 1, 8'd0, 33'd131070, 16'd2, 9'd3));
    dir_rows.push_back(mk_row(val_pkg::KindPlay, 8'd1, 16'd0, 8'd0, 16'd0,
                              1, 0, 1, 8'd0, 33'd131070, 16'd2, 9'd3));
    dir_rows.push_back(mk_row(val_pkg::KindStopOne, 8'd255, 16'd0, 8'd0, 16'd0,
                              1, 0, 1, 8'd1, 33'd65535, 16'd1, 9'd3));
    // Register over a live slot with a voice still playing.
    dir_rows.push_back(mk_row(val_pkg::KindRegister, 8'd255, 16'd100, 8'd5, 16'd0,
                              0, 0, 0, 8'd0, 33'd0, 16'd0, 9'd0));
    dir_rows.push_back(mk_row(val_pkg::KindPlay, 8'd0, 16'd0, 8'd0, 16'd0,
                              0, 0, 0, 8'd0, 33'd0, 16'd0, 9'd0));
    dir_rows.push_back(mk_row(val_pkg::KindPlay, 8'd0, 16'd0, 8'd0, 16'd0,
                              0, 0, 0, 8'd0, 33'd0, 16'd0, 9'd0));
    dir_rows.push_back(mk_row(val_pkg::KindStopAll, 8'd0, 16'd0, 8'd0, 16'd0,
                              0, 0, 0, 8'd0, 33'd0, 16'd0, 9'd0));
    // Stop one with nothing playing.
    dir_rows.push_back(mk_row(val_pkg::KindStopOne, 8'd0, 16'd0, 8'd0, 16'd0,
                              0, 0, 0, 8'd0, 33'd0, 16'd0, 9'd0));
    dir_rows.push_back(mk_row(val_pkg::KindTick, 8'd0, 16'd0, 8'd0, 16'd0,
                              0, 0, 0, 8'd0, 33'd0, 16'd0, 9'd0));
    dir_rows.push_back(mk_row(val_pkg::KindPlay, 8'd170, 16'd0, 8'd0, 16'd0,
                              0, 0, 0, 8'd0, 33'd0, 16'd0, 9'd0));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_pct = 8;
    foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].fixed, dir_rows[i].res);

    // Tight global limit, then zero, then the widest.
    set_voice_cap(16'd5);
    run_random(600);
    idle_pct = 64;
    set_voice_cap(16'd0);
    run_random(150);
    set_voice_cap(16'hFFFF);
    run_random(400);

    // Fill every slot, then run flat out.
    idle_pct = 0;
    set_voice_cap(16'd12);
    for (int i = 0; i < val_pkg::NumSounds; i++)
      send_item({val_pkg::KindRegister, 8'(i), 16'($urandom), 8'($urandom), 16'($urandom)},
                1'b0, '0);
    run_random(300);

    // Return to the reset limit and keep going.
    set_voice_cap(val_pkg::GlobalLimitRst);
    run_random(150);

    // Drain and let the pipeline settle.
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
